FILE: design/collinear_segment_merger_top_defines.svh
// Assertion macros used by the merger back end.
`ifndef COLLINEAR_SEGMENT_MERGER_TOP_DEFINES_SVH
`define COLLINEAR_SEGMENT_MERGER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/csm_pkg.sv
// Types, constants and helpers for the collinear segment merger.
package csm_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int COS_W           = 16;
  localparam logic [COS_W-1:0] COS_RESET = 16'd61584;

  typedef enum logic [1:0] {
    OP_START,
    OP_SKIP,
    OP_TEST
  } seg_op_t;

  typedef struct packed {
    seg_op_t op;
    logic    last;
  } csm_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_CMP,
    BK_APPLY,
    BK_BREAK,
    BK_FLUSH
  } bk_state_t;

  // queue entry: ctl, four endpoint coordinates, current and previous direction
  function automatic int entry_bits(int cb);
    return $bits(csm_ctl_t) + 4 * cb + 4 * (cb + 1);
  endfunction

endpackage

FILE: design/collinear_segment_merger_top.sv
// Tested segment: the back end steps through head decode, 10 products on one
// shared multiplier, compare and apply.
// Throughput is set by the shared multiplier, which works on one tested segment at a time;
// the 2-entry queue lets the front take segments while the back end works.
// A result beat shows on out_valid in the cycle after it is loaded.
// Reset (rst_n low, synchronous) empties queue and output, closes the group, threshold 61584.
module collinear_segment_merger_top import csm_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [COS_W-1:0]             cfg_cos_threshold,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  logic signed [COORD_BITS-1:0] in_seg_end_y,
  input  logic                         in_last_in_group,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_line_start_x,
  output logic signed [COORD_BITS-1:0] out_line_start_y,
  output logic signed [COORD_BITS-1:0] out_line_end_x,
  output logic signed [COORD_BITS-1:0] out_line_end_y,
  output logic                         out_group_closed,
  output logic                         out_last_result
);

  localparam int EW = entry_bits(COORD_BITS);

  logic          q_push, q_pop, q_empty, q_full;
  logic [EW-1:0] q_wdata, q_rdata;

  csm_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seg_start_x   (in_seg_start_x),
    .in_seg_start_y   (in_seg_start_y),
    .in_seg_end_x     (in_seg_end_x),
    .in_seg_end_y     (in_seg_end_y),
    .in_last_in_group (in_last_in_group),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  csm_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head_data (q_rdata),
    .empty     (q_empty),
    .full      (q_full)
  );

  csm_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_cos_threshold (cfg_cos_threshold),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_start_x  (out_line_start_x),
    .out_line_start_y  (out_line_start_y),
    .out_line_end_x    (out_line_end_x),
    .out_line_end_y    (out_line_end_y),
    .out_group_closed  (out_group_closed),
    .out_last_result   (out_last_result)
  );

endmodule

FILE: design/csm_front.sv
// Front end: takes segment beats, tracks group and direction, classifies.
module csm_front import csm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_seg_start_x,
  input  logic signed [COORD_BITS-1:0]        in_seg_start_y,
  input  logic signed [COORD_BITS-1:0]        in_seg_end_x,
  input  logic signed [COORD_BITS-1:0]        in_seg_end_y,
  input  logic                                in_last_in_group,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [entry_bits(COORD_BITS)-1:0]   q_data
);

  localparam int DIR_W = COORD_BITS + 1;

  logic                    group_open_r, group_open_nxt;
  logic signed [DIR_W-1:0] pdx_r, pdx_nxt;
  logic signed [DIR_W-1:0] pdy_r, pdy_nxt;
  logic signed [DIR_W-1:0] dx, dy;
  logic                    d_zero, pd_zero;
  csm_ctl_t                ctl;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  assign dx      = DIR_W'(in_seg_end_x) - DIR_W'(in_seg_start_x);
  assign dy      = DIR_W'(in_seg_end_y) - DIR_W'(in_seg_start_y);
  assign d_zero  = (dx == '0) && (dy == '0);
  assign pd_zero = (pdx_r == '0) && (pdy_r == '0);

  always_comb begin
    ctl.last       = in_last_in_group;
    ctl.op         = OP_START;
    group_open_nxt = group_open_r;
    pdx_nxt        = pdx_r;
    pdy_nxt        = pdy_r;
    if (!group_open_r) begin
      ctl.op         = OP_START;
      group_open_nxt = ~in_last_in_group;
      pdx_nxt        = dx;
      pdy_nxt        = dy;
    end else begin
      if (d_zero || pd_zero) begin
        ctl.op = OP_SKIP;
      end else begin
        ctl.op  = OP_TEST;
        pdx_nxt = dx;
        pdy_nxt = dy;
      end
      if (in_last_in_group) begin
        group_open_nxt = 1'b0;
      end
    end
  end

  assign q_data = {ctl, in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y,
                   dx, dy, pdx_r, pdy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_open_r <= 1'b0;
      pdx_r        <= '0;
      pdy_r        <= '0;
    end else if (q_push) begin
      group_open_r <= group_open_nxt;
      pdx_r        <= pdx_nxt;
      pdy_r        <= pdy_nxt;
    end
  end

endmodule

FILE: design/csm_fifo.sv
// Small flop queue between front and back.
module csm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/csm_back.sv
// Back end: collinearity test on a shared multiplier, run tracking, result beats.
module csm_back import csm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [COS_W-1:0]                    cfg_cos_threshold,
  input  logic                                q_empty,
  input  logic [entry_bits(COORD_BITS)-1:0]   q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS-1:0]        out_line_start_x,
  output logic signed [COORD_BITS-1:0]        out_line_start_y,
  output logic signed [COORD_BITS-1:0]        out_line_end_x,
  output logic signed [COORD_BITS-1:0]        out_line_end_y,
  output logic                                out_group_closed,
  output logic                                out_last_result
);

  `include "collinear_segment_merger_top_defines.svh"

  localparam int C     = COORD_BITS;
  localparam int DIR_W = C + 1;
  localparam int MAG_W = C;
  localparam int SUM_W = C + 1;
  localparam int DOT_W = 2 * C + 2;           // signed dot product
  localparam int MW    = 2 * C + 1;           // |dot| and squared norms
  localparam int LW    = 4 * C + 2;           // dot^2
  localparam int CC_W  = 2 * COS_W;           // threshold squared
  localparam int MOP   = (MW > CC_W) ? MW : CC_W;
  localparam int TW    = CC_W + MW;           // c^2 * n1
  localparam int TH_W  = TW - MOP;
  localparam int RW    = TW + MW;             // c^2 * n1 * n2

  localparam logic [3:0] ST_DOT_X = 4'd0;
  localparam logic [3:0] ST_DOT_Y = 4'd1;
  localparam logic [3:0] ST_N1_X  = 4'd2;
  localparam logic [3:0] ST_N1_Y  = 4'd3;
  localparam logic [3:0] ST_N2_X  = 4'd4;
  localparam logic [3:0] ST_N2_Y  = 4'd5;
  localparam logic [3:0] ST_DOTSQ = 4'd6;
  localparam logic [3:0] ST_T     = 4'd7;
  localparam logic [3:0] ST_LO    = 4'd8;
  localparam logic [3:0] ST_HI    = 4'd9;

  typedef enum logic [1:0] {
    RUN_HOLD,
    RUN_START,
    RUN_TAKE
  } run_op_t;

  // head of queue
  csm_ctl_t                h_ctl;
  logic signed [C-1:0]     h_sx, h_sy, h_ex, h_ey;
  logic signed [DIR_W-1:0] h_dx, h_dy, h_pdx, h_pdy;

  assign {h_ctl, h_sx, h_sy, h_ex, h_ey, h_dx, h_dy, h_pdx, h_pdy} = q_data;

  bk_state_t  state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  logic [COS_W-1:0] cos_r;
  logic [CC_W-1:0]  cc_r;

  logic signed [DOT_W-1:0] dot_r;
  logic [MW-1:0]           n1_r, n2_r;
  logic [LW-1:0]           lhs_r;
  logic [TW-1:0]           t_r;
  logic [MOP+MW-1:0]       lo_r;
  logic [TH_W+MW-1:0]      hi_r;
  logic                    col_r;

  logic signed [C-1:0]     min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [SUM_W-1:0] min_s_r, max_s_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [C-1:0]     out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic                    out_group_closed_r, out_last_result_r;

  // sequencer outputs
  logic    out_free, out_load, load_closed, load_last;
  run_op_t run_op;

  assign out_free = ~out_valid_r | ~out_stall;

  // ---------------- magnitudes and multiplier ----------------
  logic signed [DIR_W-1:0] ax_neg, ay_neg, bx_neg, by_neg;
  logic [MAG_W-1:0]        ax_mag, ay_mag, bx_mag, by_mag;
  logic signed [DOT_W-1:0] dot_neg;
  logic [MW-1:0]           dot_mag;
  logic [MOP-1:0]          mul_a, mul_b;
  logic [2*MOP-1:0]        prod;
  logic signed [DOT_W-1:0] dterm;
  logic                    dneg;

  assign ax_neg  = -h_pdx;
  assign ay_neg  = -h_pdy;
  assign bx_neg  = -h_dx;
  assign by_neg  = -h_dy;
  assign ax_mag  = h_pdx[C] ? ax_neg[MAG_W-1:0] : h_pdx[MAG_W-1:0];
  assign ay_mag  = h_pdy[C] ? ay_neg[MAG_W-1:0] : h_pdy[MAG_W-1:0];
  assign bx_mag  = h_dx[C]  ? bx_neg[MAG_W-1:0] : h_dx[MAG_W-1:0];
  assign by_mag  = h_dy[C]  ? by_neg[MAG_W-1:0] : h_dy[MAG_W-1:0];
  assign dot_neg = -dot_r;
  assign dot_mag = dot_r[DOT_W-1] ? dot_neg[MW-1:0] : dot_r[MW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      ST_DOT_X: begin mul_a = MOP'(ax_mag);  mul_b = MOP'(bx_mag);  end
      ST_DOT_Y: begin mul_a = MOP'(ay_mag);  mul_b = MOP'(by_mag);  end
      ST_N1_X:  begin mul_a = MOP'(ax_mag);  mul_b = MOP'(ax_mag);  end
      ST_N1_Y:  begin mul_a = MOP'(ay_mag);  mul_b = MOP'(ay_mag);  end
      ST_N2_X:  begin mul_a = MOP'(bx_mag);  mul_b = MOP'(bx_mag);  end
      ST_N2_Y:  begin mul_a = MOP'(by_mag);  mul_b = MOP'(by_mag);  end
      ST_DOTSQ: begin mul_a = MOP'(dot_mag); mul_b = MOP'(dot_mag); end
      ST_T:     begin mul_a = MOP'(cc_r);    mul_b = MOP'(n1_r);    end
      ST_LO:    begin mul_a = t_r[MOP-1:0];  mul_b = MOP'(n2_r);    end
      ST_HI:    begin mul_a = MOP'(t_r[TW-1:MOP]); mul_b = MOP'(n2_r); end
      default:  begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign dneg  = (step_r == ST_DOT_X) ? (h_pdx[C] ^ h_dx[C]) : (h_pdy[C] ^ h_dy[C]);
  assign dterm = dneg ? -$signed(prod[DOT_W-1:0]) : $signed(prod[DOT_W-1:0]);

  // full compare: dot^2 * 2^32 against c^2 * n1 * n2
  logic [RW-1:0] rhs, lhs_ext;
  assign rhs     = (RW'(hi_r) << MOP) + RW'(lo_r);
  assign lhs_ext = {lhs_r, {CC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (state_r == BK_MUL) begin
      case (step_r)
        ST_DOT_X: dot_r <= dterm;
        ST_DOT_Y: dot_r <= dot_r + dterm;
        ST_N1_X:  n1_r  <= prod[MW-1:0];
        ST_N1_Y:  n1_r  <= n1_r + prod[MW-1:0];
        ST_N2_X:  n2_r  <= prod[MW-1:0];
        ST_N2_Y:  n2_r  <= n2_r + prod[MW-1:0];
        ST_DOTSQ: lhs_r <= prod[LW-1:0];
        ST_T:     t_r   <= prod[TW-1:0];
        ST_LO:    lo_r  <= prod[MOP+MW-1:0];
        ST_HI:    hi_r  <= prod[TH_W+MW-1:0];
        default:  dot_r <= dot_r;
      endcase
    end
    if (state_r == BK_CMP) begin
      col_r <= lhs_ext > rhs;
    end
  end

  // ---------------- threshold register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COS_RESET;
    end else if (cfg_wr_en) begin
      cos_r <= cfg_cos_threshold;
    end
  end

  always_ff @(posedge clk) begin
    cc_r <= cos_r * cos_r;
  end

  // ---------------- run extremes ----------------
  logic signed [SUM_W-1:0] ss, se;
  logic signed [C-1:0]     st_min_x, st_min_y, st_max_x, st_max_y;
  logic signed [SUM_W-1:0] st_min_s, st_max_s;
  logic signed [C-1:0]     m1_x, m1_y, tk_min_x, tk_min_y;
  logic signed [C-1:0]     x1_x, x1_y, tk_max_x, tk_max_y;
  logic signed [SUM_W-1:0] m1_s, tk_min_s, x1_s, tk_max_s;

  assign ss = SUM_W'(h_sx) + SUM_W'(h_sy);
  assign se = SUM_W'(h_ex) + SUM_W'(h_ey);

  always_comb begin
    // new run: start point first, end point only if strictly better
    st_min_x = h_sx; st_min_y = h_sy; st_min_s = ss;
    st_max_x = h_sx; st_max_y = h_sy; st_max_s = ss;
    if (se < ss) begin
      st_min_x = h_ex; st_min_y = h_ey; st_min_s = se;
    end
    if (se > ss) begin
      st_max_x = h_ex; st_max_y = h_ey; st_max_s = se;
    end
    // extend run: start point, then end point
    m1_x = min_x_r; m1_y = min_y_r; m1_s = min_s_r;
    if (ss < min_s_r) begin
      m1_x = h_sx; m1_y = h_sy; m1_s = ss;
    end
    tk_min_x = m1_x; tk_min_y = m1_y; tk_min_s = m1_s;
    if (se < m1_s) begin
      tk_min_x = h_ex; tk_min_y = h_ey; tk_min_s = se;
    end
    x1_x = max_x_r; x1_y = max_y_r; x1_s = max_s_r;
    if (ss > max_s_r) begin
      x1_x = h_sx; x1_y = h_sy; x1_s = ss;
    end
    tk_max_x = x1_x; tk_max_y = x1_y; tk_max_s = x1_s;
    if (se > x1_s) begin
      tk_max_x = h_ex; tk_max_y = h_ey; tk_max_s = se;
    end
  end

  always_ff @(posedge clk) begin
    case (run_op)
      RUN_START: begin
        min_x_r <= st_min_x; min_y_r <= st_min_y; min_s_r <= st_min_s;
        max_x_r <= st_max_x; max_y_r <= st_max_y; max_s_r <= st_max_s;
      end
      RUN_TAKE: begin
        min_x_r <= tk_min_x; min_y_r <= tk_min_y; min_s_r <= tk_min_s;
        max_x_r <= tk_max_x; max_y_r <= tk_max_y; max_s_r <= tk_max_s;
      end
      default: begin
        min_x_r <= min_x_r;
        max_x_r <= max_x_r;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (h_ctl.op)
            OP_START: state_nxt = BK_IDLE;
            OP_SKIP:  state_nxt = h_ctl.last ? BK_FLUSH : BK_IDLE;
            OP_TEST:  state_nxt = BK_MUL;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_MUL:   state_nxt = (step_r == ST_HI) ? BK_CMP : BK_MUL;
      BK_CMP:   state_nxt = BK_APPLY;
      BK_APPLY: begin
        if (col_r) begin
          state_nxt = h_ctl.last ? BK_FLUSH : BK_IDLE;
        end else begin
          state_nxt = BK_BREAK;
        end
      end
      BK_BREAK: begin
        if (out_free) begin
          state_nxt = h_ctl.last ? BK_FLUSH : BK_IDLE;
        end
      end
      BK_FLUSH: state_nxt = out_free ? BK_IDLE : BK_FLUSH;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    out_load    = 1'b0;
    load_closed = 1'b0;
    load_last   = 1'b0;
    run_op      = RUN_HOLD;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (h_ctl.op)
            OP_START: begin
              run_op = RUN_START;
              q_pop  = 1'b1;
            end
            OP_SKIP:  q_pop = ~h_ctl.last;
            default:  q_pop = 1'b0;
          endcase
        end
      end
      BK_APPLY: begin
        if (col_r) begin
          run_op = RUN_TAKE;
          q_pop  = ~h_ctl.last;
        end
      end
      BK_BREAK: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_closed = 1'b0;
          load_last   = ~h_ctl.last;
          run_op      = RUN_START;
          q_pop       = ~h_ctl.last;
        end
      end
      BK_FLUSH: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_closed = 1'b1;
          load_last   = 1'b1;
          q_pop       = 1'b1;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  // counter returns to the first step as the multiply phase ends
  assign step_nxt      = ((state_r == BK_MUL) && (step_r != ST_HI)) ? step_r + 1'b1 : ST_DOT_X;
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= ST_DOT_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result beat holds the run as it stood before this cycle's update
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sx_r           <= min_x_r;
      out_sy_r           <= min_y_r;
      out_ex_r           <= max_x_r;
      out_ey_r           <= max_y_r;
      out_group_closed_r <= load_closed;
      out_last_result_r  <= load_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_start_x = out_sx_r;
  assign out_line_start_y = out_sy_r;
  assign out_line_end_x   = out_ex_r;
  assign out_line_end_y   = out_ey_r;
  assign out_group_closed = out_group_closed_r;
  assign out_last_result  = out_last_result_r;

  `CSM_ASSERT_NOW(a_busy_has_head, state_r != BK_IDLE, !q_empty,
                  "back end busy with no queue head")
  `CSM_ASSERT_NOW(a_step_idle, state_r != BK_MUL, step_r == ST_DOT_X,
                  "multiply step counter running outside multiply phase")
  `CSM_ASSERT_NEXT(a_mul_to_cmp, (state_r == BK_MUL) && (step_r == ST_HI),
                   state_r == BK_CMP, "multiply phase did not end in compare")
  `CSM_ASSERT_NEXT(a_flush_beat, (state_r == BK_FLUSH) && out_free,
                   out_valid_r && out_group_closed_r && out_last_result_r,
                   "group flush did not produce a closing beat")

endmodule

FILE: tb/tb_collinear_segment_merger_top.sv
// Self-checking testbench for the collinear segment merger: directed table, random groups.
module tb_collinear_segment_merger_top import csm_pkg::*; ();

  localparam int CB = COORD_BITS_DEF;
  localparam int DW = CB + 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int DRAIN_EVERY = 60;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
    logic                 last;
  } seg_t;

  typedef struct packed {
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
    logic                 group_closed;
    logic                 last_result;
  } line_t;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [COS_W-1:0] cfg_val;
    seg_t       seg;
    logic [1:0] n_typed;
    line_t      typed_a;
    line_t      typed_b;
  } dir_row_t;

  localparam line_t NO_LINE = '0;

  localparam dir_row_t DIRECTED_ROWS [28] = '{
    // plain two-segment group right after reset
    '{ROW_TYPED, 16'd0, '{0, 0, 16, 0, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{16, 0, 32, 0, 1'b1}, 2'd1,
      '{0, 0, 32, 0, 1'b1, 1'b1}, NO_LINE},
    // single-segment group: nothing out
    '{ROW_TYPED, 16'd0, '{5, 5, 9, 9, 1'b1}, 2'd0, NO_LINE, NO_LINE},
    // full-scale antiparallel pair
    '{ROW_TYPED, 16'd0, '{-32768, -32768, 32767, 32767, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{32767, 32767, -32768, -32768, 1'b1}, 2'd1,
      '{-32768, -32768, 32767, 32767, 1'b1, 1'b1}, NO_LINE},
    // break mid group, then break on the last segment
    '{ROW_TYPED, 16'd0, '{0, 0, 16, 0, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{16, 0, 16, 16, 1'b0}, 2'd1,
      '{0, 0, 16, 0, 1'b0, 1'b1}, NO_LINE},
    '{ROW_TYPED, 16'd0, '{16, 16, 0, 32, 1'b1}, 2'd2,
      '{16, 0, 16, 16, 1'b0, 1'b0}, '{16, 16, 16, 16, 1'b1, 1'b1}},
    // zero-length segment inside a group is skipped
    '{ROW_TYPED, 16'd0, '{0, 0, 32, 32, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{40, 40, 40, 40, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{32, 32, 64, 64, 1'b1}, 2'd1,
      '{0, 0, 64, 64, 1'b1, 1'b1}, NO_LINE},
    // zero-length first segment: rest of group skipped
    '{ROW_TYPED, 16'd0, '{8, 8, 8, 8, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{0, 0, 100, 3, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{200, -50, 0, 0, 1'b1}, 2'd1,
      '{8, 8, 8, 8, 1'b1, 1'b1}, NO_LINE},
    // equal x+y everywhere: first point taken wins
    '{ROW_TYPED, 16'd0, '{0, 16, 16, 0, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{32, -16, -16, 32, 1'b1}, 2'd1,
      '{0, 16, 0, 16, 1'b1, 1'b1}, NO_LINE},
    // threshold zero: only a zero dot product breaks
    '{ROW_CFG, 16'd0, '0, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{0, 0, 16, 0, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_TYPED, 16'd0, '{16, 0, 16, 16, 1'b1}, 2'd2,
      '{0, 0, 16, 0, 1'b0, 1'b0}, '{16, 0, 16, 16, 1'b1, 1'b1}},
    '{ROW_PRED, 16'd0, '{0, 0, 16, 0, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_PRED, 16'd0, '{16, 0, 32, 1, 1'b1}, 2'd0, NO_LINE, NO_LINE},
    // threshold max: only exact parallels merge
    '{ROW_CFG, 16'hFFFF, '0, 2'd0, NO_LINE, NO_LINE},
    '{ROW_PRED, 16'd0, '{0, 0, 16, 16, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_PRED, 16'd0, '{16, 16, 48, 48, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_PRED, 16'd0, '{48, 48, 80, 81, 1'b1}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_PRED, 16'd0, '{32767, -32768, -32768, 32767, 1'b0}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_PRED, 16'd0, '{-32768, 32767, 32767, -32768, 1'b1}, 2'd0, NO_LINE, NO_LINE},
    '{ROW_CFG, COS_RESET, '0, 2'd0, NO_LINE, NO_LINE}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [COS_W-1:0]     cfg_cos_threshold;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CB-1:0] in_seg_start_x;
  logic signed [CB-1:0] in_seg_start_y;
  logic signed [CB-1:0] in_seg_end_x;
  logic signed [CB-1:0] in_seg_end_y;
  logic                 in_last_in_group;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CB-1:0] out_line_start_x;
  logic signed [CB-1:0] out_line_start_y;
  logic signed [CB-1:0] out_line_end_x;
  logic signed [CB-1:0] out_line_end_y;
  logic                 out_group_closed;
  logic                 out_last_result;

  collinear_segment_merger_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_cos_threshold(cfg_cos_threshold),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seg_start_x   (in_seg_start_x),
    .in_seg_start_y   (in_seg_start_y),
    .in_seg_end_x     (in_seg_end_x),
    .in_seg_end_y     (in_seg_end_y),
    .in_last_in_group (in_last_in_group),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_start_x (out_line_start_x),
    .out_line_start_y (out_line_start_y),
    .out_line_end_x   (out_line_end_x),
    .out_line_end_y   (out_line_end_y),
    .out_group_closed (out_group_closed),
    .out_last_result  (out_last_result)
  );

  // predictor state
  logic [COS_W-1:0]     cos_thr;
  logic                 group_is_open;
  logic signed [DW-1:0] last_dir_x, last_dir_y;
  logic signed [CB-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [DW-1:0] lo_sum, hi_sum;

  line_t pending_lines [$];
  int    mismatch_count = 0;
  int    beat_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0d want %0d", beat_count, name, got, want));
  endtask

  task automatic queue_line(input line_t l);
    pending_lines = {pending_lines, l};
  endtask

  // |dot| > c*|a|*|b|, squared and scaled so it stays in integers
  function automatic bit dirs_collinear(input logic signed [DW-1:0] ax, ay, bx, by);
    logic signed [127:0] dot, norm_a, norm_b, thr, lhs, rhs;
    dot    = ax * bx + ay * by;
    norm_a = ax * ax + ay * ay;
    norm_b = bx * bx + by * by;
    thr    = $signed({112'd0, cos_thr});
    lhs    = (dot * dot) <<< 32;
    rhs    = thr * thr * norm_a * norm_b;
    return lhs > rhs;
  endfunction

  task automatic take_point(input logic signed [CB-1:0] x, y);
    logic signed [DW-1:0] sum;
    sum = x + y;
    if (sum < lo_sum) begin
      lo_x = x; lo_y = y; lo_sum = sum;
    end
    if (sum > hi_sum) begin
      hi_x = x; hi_y = y; hi_sum = sum;
    end
  endtask

  task automatic open_run(input seg_t s);
    lo_x = s.sx; lo_y = s.sy;
    lo_sum = $signed(s.sx) + $signed(s.sy);
    hi_x = s.sx; hi_y = s.sy; hi_sum = lo_sum;
    take_point(s.ex, s.ey);
  endtask

  task automatic emit_line(input logic closed, input logic last_one, input bit keep);
    line_t l;
    l = '{lo_x, lo_y, hi_x, hi_y, closed, last_one};
    if (keep) queue_line(l);
  endtask

  task automatic apply_segment(input seg_t s, input bit keep);
    logic signed [DW-1:0] dx, dy;
    dx = $signed(s.ex) - $signed(s.sx);
    dy = $signed(s.ey) - $signed(s.sy);
    if (!group_is_open) begin
      open_run(s);
      last_dir_x = dx; last_dir_y = dy;
      group_is_open = !s.last;
      return;
    end
    // a zero direction on either side skips the segment
    if ((dx != 0 || dy != 0) && (last_dir_x != 0 || last_dir_y != 0)) begin
      if (dirs_collinear(last_dir_x, last_dir_y, dx, dy)) begin
        take_point(s.sx, s.sy);
        take_point(s.ex, s.ey);
      end else begin
        emit_line(1'b0, !s.last, keep);
        open_run(s);
      end
      last_dir_x = dx; last_dir_y = dy;
    end
    if (s.last) begin
      emit_line(1'b1, 1'b1, keep);
      group_is_open = 1'b0;
    end
  endtask

  task automatic send_segment(input seg_t s, input bit predict);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_seg_start_x   <= s.sx;
    in_seg_start_y   <= s.sy;
    in_seg_end_x     <= s.ex;
    in_seg_end_y     <= s.ey;
    in_last_in_group <= s.last;
    apply_segment(s, predict);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_lines_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [COS_W-1:0] v);
    wait_lines_drained();
    // segments that make no line may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en         <= 1'b1;
    cfg_cos_threshold <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cos_thr = v;
  endtask

  // one group: mostly a chained polyline with drifting direction
  task automatic send_random_group(output int n_sent);
    seg_t s;
    int   n, mode, px, py, ddx, ddy, vx, vy;
    mode = $urandom_range(0, 9);  // 0: noise, 1: scrambled last flags
    n    = $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0) begin
      px = int'($urandom_range(0, 65535)) - 32768;
      py = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      px = int'($urandom_range(0, 4000)) - 2000;
      py = int'($urandom_range(0, 4000)) - 2000;
    end
    if ($urandom_range(0, 4) == 0) begin
      ddx = int'($urandom_range(0, 65535)) - 32768;
      ddy = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      ddx = int'($urandom_range(0, 400)) - 200;
      ddy = int'($urandom_range(0, 400)) - 200;
    end
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 11))
        0: begin
          vx = 0; vy = 0;
        end
        1, 2: begin
          ddx = int'($urandom_range(0, 400)) - 200;
          ddy = int'($urandom_range(0, 400)) - 200;
          vx = ddx; vy = ddy;
        end
        3: begin
          ddx = -ddx; ddy = -ddy;
          vx = ddx; vy = ddy;
        end
        default: begin
          ddx += int'($urandom_range(0, 6)) - 3;
          ddy += int'($urandom_range(0, 6)) - 3;
          vx = ddx; vy = ddy;
        end
      endcase
      if (mode == 0) begin
        s.sx = CB'($urandom); s.sy = CB'($urandom);
        s.ex = CB'($urandom); s.ey = CB'($urandom);
        s.last = 1'($urandom_range(0, 1));
      end else begin
        s.sx = CB'(px); s.sy = CB'(py);
        s.ex = CB'(px + vx); s.ey = CB'(py + vy);
        s.last = (mode == 1) ? ($urandom_range(0, 3) == 0) : (k == n - 1);
        px = int'($signed(s.ex));
        py = int'($signed(s.ey));
      end
      send_segment(s, 1'b1);
    end
    n_sent = n;
  endtask

  always @(posedge clk) begin : result_check
    line_t want;
    if (rst_n && out_valid && !out_stall) begin
      beat_count++;
      if (pending_lines.size() == 0) begin
        report_mismatch($sformatf("beat %0d with nothing expected", beat_count));
      end else begin
        want = pending_lines.pop_front();
        check_field("line_start_x", out_line_start_x, want.start_x);
        check_field("line_start_y", out_line_start_y, want.start_y);
        check_field("line_end_x", out_line_end_x, want.end_x);
        check_field("line_end_y", out_line_end_y, want.end_y);
        check_field("group_closed", out_group_closed, want.group_closed);
        check_field("last_result", out_last_result, want.last_result);
      end
    end
  end

  initial begin
    int sent, got, next_drain;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_cos_threshold = '0;
    in_valid          = 1'b0;
    in_seg_start_x    = '0;
    in_seg_start_y    = '0;
    in_seg_end_x      = '0;
    in_seg_end_y      = '0;
    in_last_in_group  = 1'b0;
    cos_thr           = COS_RESET;
    group_is_open     = 1'b0;
    last_dir_x = '0; last_dir_y = '0;
    lo_x = '0; lo_y = '0; lo_sum = '0;
    hi_x = '0; hi_y = '0; hi_sum = '0;
    send_idle_pct = 34;
    recv_idle_pct = 74;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      case (DIRECTED_ROWS[i].kind)
        ROW_CFG: write_threshold(DIRECTED_ROWS[i].cfg_val);
        ROW_TYPED: begin
          if (DIRECTED_ROWS[i].n_typed > 0) queue_line(DIRECTED_ROWS[i].typed_a);
          if (DIRECTED_ROWS[i].n_typed > 1) queue_line(DIRECTED_ROWS[i].typed_b);
          send_segment(DIRECTED_ROWS[i].seg, 1'b0);
        end
        default: send_segment(DIRECTED_ROWS[i].seg, 1'b1);
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34; recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74; recv_idle_pct = 34;
          write_threshold(COS_W'($urandom_range(0, 65535)));
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_threshold(COS_W'($urandom_range(55000, 65535)));
        end
      endcase
      sent = 0;
      next_drain = DRAIN_EVERY;
      while (sent < ITEMS_PER_PHASE) begin
        send_random_group(got);
        sent += got;
        if (sent >= next_drain) begin
          wait_lines_drained();
          next_drain += DRAIN_EVERY;
        end
      end
    end

    wait_lines_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_lines.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
